// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("lswf check failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("lswf check failed");

`endif

// ===== design/lswf_pkg.sv =====
// ---------------------------------------------------------------------------
// lswf_pkg
// Shared types, widths and constants of the lidar wall and front ranger.
// ---------------------------------------------------------------------------
package lswf_pkg;

    localparam int DEF_CORDIC_STEPS  = 16;
    localparam int DEF_SENSOR_OFFSET = 655;
    localparam int MAX_CORDIC_STEPS  = 24;

    localparam int XW  = 36;  // CORDIC x/y datapath
    localparam int ZW  = 33;  // CORDIC angle, scaled by 2^30
    localparam int UW  = 26;  // magnitude after the offset
    localparam int SQW = 2 * UW;
    localparam int RW  = UW;  // root bits

    localparam logic [15:0] CORDIC_GAIN = 16'd39797;

    localparam logic signed [23:0] LEFT_LO   = 24'sd11436;
    localparam logic signed [23:0] LEFT_HI   = 24'sd14295;
    localparam logic signed [23:0] FRONT_LIM = 24'sd2130;
    localparam logic [15:0]        SIDE_MIN  = 16'd410;
    localparam logic signed [16:0] LAT_CLAMP = 17'sd819;
    localparam logic signed [16:0] OUT_CLAMP = 17'sd8192;

    localparam logic [29:0] ATAN_TAB [MAX_CORDIC_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
    };

    typedef enum logic [2:0] {
        CFG_ANGLE_START   = 3'd0,
        CFG_ANGLE_STEP    = 3'd1,
        CFG_RANGE_FLOOR   = 3'd2,
        CFG_RANGE_CEILING = 3'd3,
        CFG_WALL_TARGET   = 3'd4,
        CFG_SIDE_LIMIT    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic front;
    } item_ctrl_t;

    typedef logic signed [XW-1:0] cordic_t;
    typedef logic signed [ZW-1:0] angle_t;

endpackage

// ===== design/lswf_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// lswf_cordic_cell
// One rotation step of the rotation-mode chain, registered.
// ---------------------------------------------------------------------------
module lswf_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  lswf_pkg::item_ctrl_t  ctrl_in,
    input  lswf_pkg::cordic_t     x_in,
    input  lswf_pkg::cordic_t     y_in,
    input  lswf_pkg::angle_t      z_in,
    output lswf_pkg::item_ctrl_t  ctrl_out,
    output lswf_pkg::cordic_t     x_out,
    output lswf_pkg::cordic_t     y_out,
    output lswf_pkg::angle_t      z_out
);
    import lswf_pkg::*;

    localparam angle_t ATAN = angle_t'({3'b000, ATAN_TAB[STEP]});

    item_ctrl_t ctrl_reg;
    cordic_t    x_reg, y_reg, x_next, y_next;
    angle_t     z_reg, z_next;

    always_comb begin
        if (!z_in[ZW-1]) begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_in;
        end
        if (adv) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

// ===== design/lswf_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// lswf_sqrt_cell
// One digit of a restoring square root, registered.
// ---------------------------------------------------------------------------
module lswf_sqrt_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  lswf_pkg::item_ctrl_t          ctrl_in,
    input  logic [lswf_pkg::SQW-1:0]      rad_in,
    input  logic [lswf_pkg::RW+1:0]       rem_in,
    input  logic [lswf_pkg::RW-1:0]       root_in,
    output lswf_pkg::item_ctrl_t          ctrl_out,
    output logic [lswf_pkg::SQW-1:0]      rad_out,
    output logic [lswf_pkg::RW+1:0]       rem_out,
    output logic [lswf_pkg::RW-1:0]       root_out
);
    import lswf_pkg::*;

    item_ctrl_t       ctrl_reg;
    logic [SQW-1:0]   rad_reg;
    logic [RW+1:0]    rem_reg, rem_next, rem_shift, trial;
    logic [RW-1:0]    root_reg, root_next;

    always_comb begin
        rem_shift = {rem_in[RW-1:0], rad_in[SQW-1 -: 2]};
        trial     = {root_in, 2'b01};
        if (rem_shift >= trial) begin
            rem_next  = rem_shift - trial;
            root_next = {root_in[RW-2:0], 1'b1};
        end else begin
            rem_next  = rem_shift;
            root_next = {root_in[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_in;
        end
        if (adv) begin
            rad_reg  <= {rad_in[SQW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== design/lidar_scan_wall_and_front_ranger.sv =====
// ---------------------------------------------------------------------------
// lidar_scan_wall_and_front_ranger
// Per-scan side wall minimums, lateral error and forward distance.
// ---------------------------------------------------------------------------
//  channel | dir | handshake                    | content
//  s_*     | in  | s_tvalid / s_tready          | tdata range, tuser invalid, tlast end
//  m_*     | out | m_tvalid / m_tready          | tdata error+distance, tuser seen flags
//  cfg_*   | in  | cfg_valid / cfg_ready (=1)   | cfg_index, cfg_data
//
//  One request is in flight at a time: it runs a registered multiply stage,
//  CORDIC_STEPS rotation cells, three magnitude stages, RW (26) square-root
//  cells and a tail. Reset (aresetn low, synchronous) empties the chains and
//  loads register defaults. A held result stalls the whole chain only when a
//  second scan result reaches the tail; no input is taken meanwhile.
// ---------------------------------------------------------------------------
module lidar_scan_wall_and_front_ranger #(
    parameter int CORDIC_STEPS  = lswf_pkg::DEF_CORDIC_STEPS,
    parameter int SENSOR_OFFSET = lswf_pkg::DEF_SENSOR_OFFSET
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_range
    input  logic        s_tuser,   // [0] sample_invalid
    input  logic        s_tlast,   // scan_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] steer_error, [30:15] front_distance, [31] zero
    output logic [2:0]  m_tuser,   // [0] front_seen, [1] left_seen, [2] right_seen
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lswf_pkg::*;

    localparam cordic_t OFFS = cordic_t'(SENSOR_OFFSET * 256);

    // configuration registers
    logic signed [15:0] angle_start_reg;
    logic [12:0]        angle_step_reg;
    logic [15:0]        range_floor_reg, range_ceiling_reg;
    logic [13:0]        wall_target_reg;
    logic [14:0]        side_limit_reg;

    // scan state
    logic signed [23:0] beam_reg;
    logic [15:0]        left_reg, right_reg, front_near_reg;
    logic               front_hit_reg, fresh_reg, busy_reg;

    // output register
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic [2:0]         m_user_reg;

    logic accept, adv, tail_fire;

    // tail results, used by the scan state below
    logic [15:0]        tail_dist, front_out;
    logic               tail_hit, tail_take, hit_out, lseen, rseen;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;

    // -------- entry: side minimums and angle accumulator --------
    logic signed [23:0] a_eff;
    logic signed [24:0] a_sum;
    logic [15:0]        ln_eff, rn_eff;
    logic               side_ok, in_left, in_right, in_front;
    logic [31:0]        gain_prod;

    always_comb begin
        a_eff    = fresh_reg ? 24'(angle_start_reg) : beam_reg;
        ln_eff   = fresh_reg ? {1'b0, side_limit_reg} : left_reg;
        rn_eff   = fresh_reg ? {1'b0, side_limit_reg} : right_reg;
        side_ok  = !s_tuser && (s_tdata >= SIDE_MIN) && (s_tdata <= {1'b0, side_limit_reg});
        in_left  = (a_eff > LEFT_LO) && (a_eff <= LEFT_HI);
        in_right = (a_eff >= -LEFT_HI) && (a_eff < -LEFT_LO);
        in_front = !s_tuser && (a_eff > -FRONT_LIM) && (a_eff < FRONT_LIM);
        a_sum    = 25'(a_eff) + 25'({12'd0, angle_step_reg});
    end

    // full 32-bit product of range and CORDIC gain
    assign gain_prod = s_tdata * CORDIC_GAIN;

    // -------- first stage: gain multiply --------
    item_ctrl_t ctrl_p_reg;
    cordic_t    x0_reg;
    angle_t     z0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_start_reg   <= -16'sd25736;
            angle_step_reg    <= 13'd143;
            range_floor_reg   <= 16'd492;
            range_ceiling_reg <= 16'd49152;
            wall_target_reg   <= 14'd1638;
            side_limit_reg    <= 15'd3277;
            fresh_reg         <= 1'b1;
            busy_reg          <= 1'b0;
            front_hit_reg     <= 1'b0;
            ctrl_p_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ANGLE_START:   angle_start_reg   <= cfg_data;
                    CFG_ANGLE_STEP:    angle_step_reg    <= cfg_data[12:0];
                    CFG_RANGE_FLOOR:   range_floor_reg   <= cfg_data;
                    CFG_RANGE_CEILING: range_ceiling_reg <= cfg_data;
                    CFG_WALL_TARGET:   wall_target_reg   <= cfg_data[13:0];
                    CFG_SIDE_LIMIT:    side_limit_reg    <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (accept) begin
                fresh_reg <= s_tlast;
                busy_reg  <= 1'b1;
                // start a new scan: clear the front record
                if (fresh_reg) begin
                    front_hit_reg <= 1'b0;
                end
            end else if (tail_fire) begin
                busy_reg <= 1'b0;
                if (tail_hit) begin
                    front_hit_reg <= 1'b1;
                end
            end
            if (adv) begin
                ctrl_p_reg <= '{valid: accept, last: s_tlast, front: in_front};
            end
        end
        if (accept) begin
            // saturate the beam angle at the top of its range
            beam_reg  <= (a_sum > 25'sd8388607) ? 24'sd8388607 : a_sum[23:0];
            left_reg  <= (side_ok && in_left && (s_tdata < ln_eff)) ? s_tdata : ln_eff;
            right_reg <= (side_ok && in_right && (s_tdata < rn_eff)) ? s_tdata : rn_eff;
            if (fresh_reg) begin
                front_near_reg <= 16'hFFFF;
            end
        end else if (tail_fire && tail_take) begin
            front_near_reg <= tail_dist;
        end
        if (adv) begin
            x0_reg <= cordic_t'({4'd0, gain_prod});
            z0_reg <= {{3{a_eff[12]}}, a_eff[12:0], 17'd0};
        end
    end

    // -------- CORDIC chain --------
    item_ctrl_t c_ctrl [CORDIC_STEPS+1];
    cordic_t    c_x    [CORDIC_STEPS+1];
    cordic_t    c_y    [CORDIC_STEPS+1];
    angle_t     c_z    [CORDIC_STEPS+1];

    assign c_ctrl[0] = ctrl_p_reg;
    assign c_x[0]    = x0_reg;
    assign c_y[0]    = '0;
    assign c_z[0]    = z0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        lswf_cordic_cell #(.STEP(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctrl_in  (c_ctrl[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .ctrl_out (c_ctrl[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1])
        );
    end

    // -------- magnitude: offset, abs, square, sum --------
    cordic_t        xs, ys;
    item_ctrl_t     ctrl_a_reg, ctrl_b_reg, ctrl_c_reg;
    logic [UW-1:0]  ux_reg, uy_reg;
    logic [SQW-1:0] sqx_reg, sqy_reg, rad_reg;
    logic [SQW:0]   sq_sum;

    always_comb begin
        xs     = (c_x[CORDIC_STEPS] >>> 8) + OFFS;
        ys     = c_y[CORDIC_STEPS] >>> 8;
        sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end else if (adv) begin
            ctrl_a_reg <= c_ctrl[CORDIC_STEPS];
            ctrl_b_reg <= ctrl_a_reg;
            ctrl_c_reg <= ctrl_b_reg;
        end
        if (adv) begin
            ux_reg  <= xs[XW-1] ? UW'(-xs) : xs[UW-1:0];
            uy_reg  <= ys[XW-1] ? UW'(-ys) : ys[UW-1:0];
            sqx_reg <= ux_reg * ux_reg;
            sqy_reg <= uy_reg * uy_reg;
            rad_reg <= sq_sum[SQW-1:0];
        end
    end

    // -------- square-root chain --------
    item_ctrl_t      s_ctrl [RW+1];
    logic [SQW-1:0]  s_rad  [RW+1];
    logic [RW+1:0]   s_rem  [RW+1];
    logic [RW-1:0]   s_root [RW+1];

    assign s_ctrl[0] = ctrl_c_reg;
    assign s_rad[0]  = rad_reg;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        lswf_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctrl_in  (s_ctrl[k]),
            .rad_in   (s_rad[k]),
            .rem_in   (s_rem[k]),
            .root_in  (s_root[k]),
            .ctrl_out (s_ctrl[k+1]),
            .rad_out  (s_rad[k+1]),
            .rem_out  (s_rem[k+1]),
            .root_out (s_root[k+1])
        );
    end

    // -------- tail: round, qualify, report --------
    item_ctrl_t         tail;
    logic [RW:0]        rnd;
    logic signed [16:0] diff, half, err, single;

    assign tail = s_ctrl[RW];

    always_comb begin
        rnd       = {1'b0, s_root[RW]} + (RW+1)'(128);
        tail_dist = (|rnd[RW:24]) ? 16'hFFFF : rnd[23:8];
        tail_hit  = tail.front && (tail_dist >= range_floor_reg) &&
                    (tail_dist <= range_ceiling_reg);
        tail_take = tail_hit && (!front_hit_reg || (tail_dist < front_near_reg));
        hit_out   = front_hit_reg || tail_hit;
        front_out = tail_take ? tail_dist : front_near_reg;
        front_out = hit_out ? front_out : 16'hFFFF;

        lseen  = left_reg < {1'b0, side_limit_reg};
        rseen  = right_reg < {1'b0, side_limit_reg};
        diff   = $signed({1'b0, right_reg}) - $signed({1'b0, left_reg});
        // halve toward zero
        half   = (diff + $signed({16'd0, diff[16]})) >>> 1;
        single = lseen ? $signed({3'd0, wall_target_reg}) - $signed({1'b0, left_reg})
                       : $signed({1'b0, right_reg}) - $signed({3'd0, wall_target_reg});
        if (lseen && rseen) begin
            err = (half > LAT_CLAMP) ? LAT_CLAMP : ((half < -LAT_CLAMP) ? -LAT_CLAMP : half);
        end else if (lseen || rseen) begin
            err = (single > OUT_CLAMP) ? OUT_CLAMP
                : ((single < -OUT_CLAMP) ? -OUT_CLAMP : single);
        end else begin
            err = '0;
        end
    end

    // hold the chain only when a scan result meets a full output register that is not being read
    assign adv       = !(tail.valid && tail.last && m_valid_reg && !m_tready);
    assign tail_fire = tail.valid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tail_fire && tail.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (tail_fire && tail.last) begin
            m_data_reg <= {1'b0, front_out, err[14:0]};
            m_user_reg <= {rseen, lseen, hit_out};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== design/lswf_checker.sv =====
// ---------------------------------------------------------------------------
// lswf_checker
// Port-level checks of the lidar wall and front ranger, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lswf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // one request in flight: the input closes right after a request
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // no front return reads as an infinite distance
    `ASSERT_IMPL(a_front_inf, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[30:15] == 16'hFFFF)
    // no wall seen steers nowhere
    `ASSERT_IMPL(a_no_wall, aclk, aresetn, m_tvalid && !m_tuser[1] && !m_tuser[2],
        m_tdata[14:0] == 15'd0)

endmodule

bind lidar_scan_wall_and_front_ranger lswf_checker u_lswf_checker (.*);

// ===== dv/lidar_scan_wall_and_front_ranger_tb.sv =====
// ---------------------------------------------------------------------------
// lidar_scan_wall_and_front_ranger_tb
// Drives lidar range samples and register writes into the ranger, predicts
// the per-scan wall error and front distance in a local model, and compares
// every scan result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module lidar_scan_wall_and_front_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lswf_pkg::*;

    localparam int STEPS  = DEF_CORDIC_STEPS;
    localparam int OFFSET = DEF_SENSOR_OFFSET;
    localparam int LATENCY = STEPS + 31;

    // Register defaults after reset.
    localparam logic signed [15:0] RST_ANGLE_START = -16'sd25736;
    localparam logic [12:0] RST_ANGLE_STEP    = 13'd143;
    localparam logic [15:0] RST_RANGE_FLOOR   = 16'd492;
    localparam logic [15:0] RST_RANGE_CEILING = 16'd49152;
    localparam logic [13:0] RST_WALL_TARGET   = 14'd1638;
    localparam logic [14:0] RST_SIDE_LIMIT    = 15'd3277;
    localparam int ANGLE_SAT = 8388607;

    typedef struct packed {
        logic signed [14:0] lat_err;
        logic [15:0]        fwd_range;
        logic               front_seen;
        logic               left_seen;
        logic               right_seen;
    } scan_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [15:0] sample_range
    logic        s_tuser = 1'b0;  // [0] sample_invalid
    logic        s_tlast = 1'b0;  // scan_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [14:0] steer_error, [30:15] front_distance
    logic [2:0]  m_tuser;         // [0] front_seen, [1] left_seen, [2] right_seen
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lidar_scan_wall_and_front_ranger dut (.*);

    // Predictor copy of registers and scan state.
    int          p_angle_start, p_angle_step, p_floor, p_ceiling, p_target, p_side;
    int          p_beam;
    int          p_left, p_right, p_front;
    bit          p_front_hit, p_fresh;

    scan_result_t scan_results_due[$];
    int          mismatches = 0;
    int          results_seen = 0;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    bit          recv_hold = 1'b0;

    // Floor shift for signed 64-bit values.
    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Rotate the range vector, add the sensor offset and take the magnitude.
    function automatic int front_range(int r, int ang);
        longint x, y, z, dx, dy, xs, ys;
        longint unsigned ux, uy, root, d;
        x = longint'(r) * CORDIC_GAIN;
        y = 0;
        z = longint'(ang) * 131072;
        for (int i = 0; i < STEPS && i < MAX_CORDIC_STEPS; i++) begin
            dx = fl_shift(y, i);
            dy = fl_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        xs = fl_shift(x, 8) + longint'(OFFSET) * 256;
        ys = fl_shift(y, 8);
        ux = xs < 0 ? -xs : xs;
        uy = ys < 0 ? -ys : ys;
        root = int_sqrt(ux * ux + uy * uy);
        d = (root + 128) >> 8;
        return d > 65535 ? 65535 : int'(d);
    endfunction

    function automatic int clamp(int v, int lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    task automatic predict_sample(logic [15:0] r, logic inv, logic last);
        int a, d, err;
        bit ls, rs;
        scan_result_t res;
        if (p_fresh) begin
            p_beam = p_angle_start;
            p_left = p_side;
            p_right = p_side;
            p_front = 65535;
            p_front_hit = 1'b0;
            p_fresh = 1'b0;
        end
        a = p_beam;
        if (!inv && r >= SIDE_MIN && r <= p_side) begin
            if (a > LEFT_LO && a <= LEFT_HI && r < p_left) p_left = r;
            if (a >= -LEFT_HI && a < -LEFT_LO && r < p_right) p_right = r;
        end
        if (!inv && a > -FRONT_LIM && a < FRONT_LIM) begin
            d = front_range(r, a);
            if (d >= p_floor && d <= p_ceiling) begin
                if (!p_front_hit || d < p_front) p_front = d;
                p_front_hit = 1'b1;
            end
        end
        p_beam = (p_beam + p_angle_step > ANGLE_SAT) ? ANGLE_SAT : p_beam + p_angle_step;
        if (last) begin
            ls = p_left < p_side;
            rs = p_right < p_side;
            err = 0;
            if (ls && rs) err = clamp((p_right - p_left) / 2, LAT_CLAMP);
            else if (ls) err = clamp(p_target - p_left, OUT_CLAMP);
            else if (rs) err = clamp(p_right - p_target, OUT_CLAMP);
            res.lat_err = err[14:0];
            res.fwd_range = p_front_hit ? p_front[15:0] : 16'hFFFF;
            res.front_seen = p_front_hit;
            res.left_seen = ls;
            res.right_seen = rs;
            scan_results_due.insert(scan_results_due.size(), res);
            p_fresh = 1'b1;
        end
    endtask

    // Send one request and update the prediction when it is accepted.
    task automatic send_sample(logic [15:0] r, logic inv, logic last);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        s_tuser <= inv;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        predict_sample(r, inv, last);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a register while the block is idle.
    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        while (scan_results_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ANGLE_START:   p_angle_start = $signed(val);
            CFG_ANGLE_STEP:    p_angle_step = val[12:0];
            CFG_RANGE_FLOOR:   p_floor = val;
            CFG_RANGE_CEILING: p_ceiling = val;
            CFG_WALL_TARGET:   p_target = val[13:0];
            CFG_SIDE_LIMIT:    p_side = val[14:0];
            default: ;
        endcase
    endtask

    // Pick a range that exercises side thresholds and front distances.
    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(380, 440));
            2: return 16'(p_side + $urandom_range(0, 4) - 2);
            3: return 16'($urandom_range(0, 4096));
            default: return 16'($urandom_range(400, p_side > 400 ? p_side : 400));
        endcase
    endfunction

    // A scan: n samples with random content, the last one ending the scan.
    task automatic send_scan(int n);
        for (int i = 0; i < n; i++)
            send_sample(pick_range(), $urandom_range(0, 9) == 0, i == n - 1);
    endtask

    task automatic test_directed();
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd410, 1'b1, 1'b1);   // ends a three-sample scan
        // short sweep: nineteen samples from the start of the span
        for (int i = 0; i < 361; i += 20)
            send_sample(16'd1000 + 16'(i), 1'b0, 1'b0);
        send_sample(16'd409, 1'b0, 1'b1);
    endtask

    // A full sweep at default step so every sector is hit.
    task automatic test_default_scans();
        send_scan(361);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_ANGLE_START, 16'(-16'sd2130));
        write_reg(CFG_ANGLE_STEP, 16'd1);
        write_reg(CFG_RANGE_FLOOR, 16'd0);
        write_reg(CFG_RANGE_CEILING, 16'hFFFF);
        write_reg(CFG_WALL_TARGET, 16'd8192);
        write_reg(CFG_SIDE_LIMIT, 16'd16384);
        repeat (4) send_scan($urandom_range(2, 12));
        // only the left sector, wall target at zero
        write_reg(CFG_ANGLE_START, 16'd12000);
        write_reg(CFG_WALL_TARGET, 16'd0);
        send_scan(6);
        // right sector only, floor above ceiling
        write_reg(CFG_ANGLE_START, 16'(-16'sd13000));
        write_reg(CFG_RANGE_FLOOR, 16'd5000);
        write_reg(CFG_RANGE_CEILING, 16'd4000);
        write_reg(CFG_WALL_TARGET, 16'd8192);
        send_scan(6);
        // step of 4096 from the top of the default span, side limit at zero
        write_reg(CFG_ANGLE_START, 16'd25736);
        write_reg(CFG_ANGLE_STEP, 16'd4096);
        write_reg(CFG_SIDE_LIMIT, 16'd0);
        send_scan(20);
        write_reg(CFG_ANGLE_START, 16'(-16'sd25736));
        write_reg(CFG_SIDE_LIMIT, 16'd32767);
        write_reg(CFG_RANGE_FLOOR, 16'd492);
        write_reg(CFG_RANGE_CEILING, 16'd49152);
        send_scan(16);
    endtask

    // Random coarse scans with random span settings; also full input width.
    task automatic test_random_scans();
        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_ANGLE_START, 16'($urandom_range(0, 2 * 25736) - 25736));
            write_reg(CFG_ANGLE_STEP, 16'($urandom_range(600, 4096)));
            write_reg(CFG_SIDE_LIMIT, 16'($urandom_range(500, 16384)));
            write_reg(CFG_WALL_TARGET, 16'($urandom_range(0, 8192)));
            repeat (3) send_scan($urandom_range(1, 14));
        end
        write_reg(CFG_ANGLE_START, 16'(-16'sd25736));
        write_reg(CFG_ANGLE_STEP, 16'd2000);
        write_reg(CFG_SIDE_LIMIT, 16'd3277);
        for (int i = 0; i < 40; i++) send_sample(16'($urandom), $urandom_range(0, 1),
                                                  $urandom_range(0, 7) == 0);
        send_sample(16'd500, 1'b0, 1'b1);
    endtask

    // Hold the receiver off so the block fills and stalls its input.
    task automatic test_backpressure();
        recv_hold = 1'b1;
        repeat (6) send_scan(3);
        recv_hold = 1'b0;
        // final part: no idling on either side
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (8) send_scan($urandom_range(2, 8));
    endtask

    // Receiver: random stalls, plus a long counted hold when requested.
    initial begin
        int hold_cnt;
        forever begin
            @(posedge aclk);
            if (recv_hold) begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 2000 && recv_hold; hold_cnt++)
                    @(posedge aclk);
                m_tready <= 1'b1;
            end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted scan result with the oldest prediction.
    always @(posedge aclk) begin
        scan_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.lat_err = m_tdata[14:0];
            got.fwd_range = m_tdata[30:15];
            got.front_seen = m_tuser[0];
            got.left_seen = m_tuser[1];
            got.right_seen = m_tuser[2];
            results_seen++;
            if (scan_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = scan_results_due.pop_front();
                if (got !== want || m_tdata[31] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: err %0d/%0d dist %0d/%0d flags %b%b%b/%b%b%b",
                            want.lat_err, got.lat_err, want.fwd_range, got.fwd_range,
                            want.front_seen, want.left_seen, want.right_seen,
                            got.front_seen, got.left_seen, got.right_seen);
                end
            end
        end
    end

    initial begin
        p_angle_start = RST_ANGLE_START;
        p_angle_step = RST_ANGLE_STEP;
        p_floor = RST_RANGE_FLOOR;
        p_ceiling = RST_RANGE_CEILING;
        p_target = RST_WALL_TARGET;
        p_side = RST_SIDE_LIMIT;
        p_fresh = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_default_scans();
        test_register_extremes();
        test_random_scans();
        test_backpressure();
        while (scan_results_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/lswf_pkg.sv
design/lswf_cordic_cell.sv
design/lswf_sqrt_cell.sv
design/lidar_scan_wall_and_front_ranger.sv
design/lswf_checker.sv
dv/lidar_scan_wall_and_front_ranger_tb.sv
